// File: hdl/bsc_pkg.sv
// Shared types, constants and helpers for the barometric compensation block.
package bsc_pkg;

	typedef struct packed {
		logic        opcode;
		logic [19:0] raw_value;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] temperature_centi;
		logic        [31:0] pressure_q8;
		logic               divide_by_zero;
	} out_item_t;

	localparam logic OP_TEMP  = 1'b0;
	localparam logic OP_PRESS = 1'b1;

	localparam logic [1:0] CFG_TEMP    = 2'd0;
	localparam logic [1:0] CFG_PRESS_A = 2'd1;
	localparam logic [1:0] CFG_PRESS_B = 2'd2;
	localparam logic [1:0] CFG_PRESS_C = 2'd3;

	localparam logic [63:0] TEMP_OFFSET = 64'd128000;
	localparam logic [63:0] RAW_BASE    = 64'd1048576;
	localparam logic [63:0] PRESS_SCALE = 64'd3125;
	localparam logic [63:0] ROUND_HALF  = 64'd128;
	localparam logic [63:0] BIAS_47     = 64'h0000_8000_0000_0000;
	localparam logic [63:0] TEMP_MULT   = 64'd5;
	localparam logic [63:0] P7_MULT     = 64'd16;

	typedef enum logic [3:0] {
		ST_T_DIFF,
		ST_T_SQ,
		ST_T_V2,
		ST_T_OUT,
		ST_P_SQ,
		ST_P_V2A,
		ST_P_V2B,
		ST_P_V1A,
		ST_P_V1B,
		ST_P_V1C,
		ST_P_NUM,
		ST_P_PS,
		ST_P_PS2,
		ST_P_P8,
		ST_P_OUT
	} step_t;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_MUL_GO,
		CS_MUL_WAIT,
		CS_WB,
		CS_DIV_GO,
		CS_DIV_WAIT,
		CS_DIV_TAKE,
		CS_OUT
	} fsm_t;

	typedef struct packed {
		logic  accept;
		logic  mul_go;
		logic  wb;
		logic  div_go;
		logic  div_take;
		logic  out_load;
		step_t step;
	} ctrl_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic div_done;
		logic div_zero;
	} dp_status_t;

	function automatic logic [63:0] sext16(input logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

	function automatic logic [63:0] sext32(input logic [31:0] v);
		return {{32{v[31]}}, v};
	endfunction

endpackage

// File: hdl/bsc_mul.sv
// Multi-cycle 64x64 multiplier returning the low 64 product bits, one 32x32 multiply per cycle.
module bsc_mul import bsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] prod
);

	logic [1:0]  phase_q;
	logic [63:0] a_q, b_q, acc_q;
	logic [31:0] hi_q;
	logic [31:0] m_a, m_b;
	logic [63:0] m_p;
	logic        done_q;

	assign m_a = (phase_q == 2'd3) ? a_q[63:32] : a_q[31:0];
	assign m_b = (phase_q == 2'd2) ? b_q[63:32] : b_q[31:0];
	assign m_p = m_a * m_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				2'd0: if (start) phase_q <= 2'd1;
				2'd1: phase_q <= 2'd2;
				2'd2: phase_q <= 2'd3;
				default: begin
					phase_q <= 2'd0;
					done_q  <= 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			2'd0: begin
				if (start) begin
					a_q <= a;
					b_q <= b;
				end
			end
			2'd1: acc_q <= m_p;
			2'd2: hi_q <= m_p[31:0];
			default: hi_q <= hi_q + m_p[31:0];
		endcase
	end

	assign done = done_q;
	assign prod = {acc_q[63:32] + hi_q, acc_q[31:0]};

endmodule

// File: hdl/bsc_div.sv
// Signed 64-bit restoring divider, truncating toward zero, one quotient bit per cycle.
module bsc_div import bsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [63:0] divisor,
	output logic        done,
	output logic [63:0] quotient
);

	logic [6:0]  count_q;
	logic        done_q;
	logic        neg_q;
	logic [63:0] quo_q, rem_q, den_q;
	logic [64:0] rem_sh, diff;

	assign rem_sh = {rem_q, quo_q[63]};
	assign diff   = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 7'd0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				count_q <= 7'd64;
			end else if (count_q != 7'd0) begin
				count_q <= count_q - 7'd1;
				if (count_q == 7'd1) done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[63] ^ divisor[63];
			quo_q <= dividend[63] ? (64'd0 - dividend) : dividend;
			den_q <= divisor[63] ? (64'd0 - divisor) : divisor;
			rem_q <= 64'd0;
		end else if (count_q != 7'd0) begin
			if (!diff[64]) begin
				rem_q <= diff[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= rem_sh[63:0];
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (64'd0 - quo_q) : quo_q;

endmodule

// File: hdl/bsc_datapath.sv
// Datapath: calibration registers, work registers, shared multiplier and divider.
module bsc_datapath import bsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  in_item_t    in_data,
	input  ctrl_cmd_t   cmd,
	output dp_status_t  status,
	output out_item_t   out_data
);

	logic [47:0] temp_cal_q;
	logic [63:0] press_a_q, press_b_q;
	logic [15:0] press_c_q;
	logic [31:0] fine_q;
	logic [19:0] raw_q;
	logic [63:0] ra_q, rb_q, rc_q, rd_q;
	logic [31:0] tcent_q, press_q;
	logic        dbz_q;
	out_item_t   out_q;

	logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
	logic [63:0] v1, ps, praw;
	logic [63:0] op_a, op_b, prod, quot;
	logic [63:0] v1_new;
	logic        mul_done, div_done;

	function automatic logic [31:0] v1_v2_low(input logic [63:0] pr);
		logic [63:0] sh;
		sh = $signed(pr) >>> 14;
		return sh[31:0];
	endfunction

	function automatic logic [31:0] asr8_low(input logic [63:0] v);
		logic [63:0] sh;
		sh = $signed(v) >>> 8;
		return sh[31:0];
	endfunction

	assign t1 = {48'd0, temp_cal_q[15:0]};
	assign t2 = sext16(temp_cal_q[31:16]);
	assign t3 = sext16(temp_cal_q[47:32]);
	assign p1 = {48'd0, press_a_q[15:0]};
	assign p2 = sext16(press_a_q[31:16]);
	assign p3 = sext16(press_a_q[47:32]);
	assign p4 = sext16(press_a_q[63:48]);
	assign p5 = sext16(press_b_q[15:0]);
	assign p6 = sext16(press_b_q[31:16]);
	assign p7 = sext16(press_b_q[47:32]);
	assign p8 = sext16(press_b_q[63:48]);
	assign p9 = sext16(press_c_q);

	assign v1     = sext32(fine_q) - TEMP_OFFSET;
	assign ps     = $signed(rd_q) >>> 13;
	assign praw   = RAW_BASE - {44'd0, raw_q};
	assign v1_new = $signed(prod) >>> 33;

	always_comb begin
		op_a = ra_q;
		op_b = rb_q;
		case (cmd.step)
			ST_T_DIFF: begin
				op_a = {47'd0, raw_q[19:3]} - {t1[62:0], 1'b0};
				op_b = t2;
			end
			ST_T_SQ: begin
				op_a = {48'd0, raw_q[19:4]} - t1;
				op_b = {48'd0, raw_q[19:4]} - t1;
			end
			ST_T_V2: begin
				op_a = rb_q;
				op_b = t3;
			end
			ST_T_OUT: begin
				op_a = sext32(fine_q);
				op_b = TEMP_MULT;
			end
			ST_P_SQ: begin
				op_a = v1;
				op_b = v1;
			end
			ST_P_V2A: begin
				op_a = ra_q;
				op_b = p6;
			end
			ST_P_V2B: begin
				op_a = v1;
				op_b = p5;
			end
			ST_P_V1A: begin
				op_a = ra_q;
				op_b = p3;
			end
			ST_P_V1B: begin
				op_a = v1;
				op_b = p2;
			end
			ST_P_V1C: begin
				op_a = rc_q;
				op_b = p1;
			end
			ST_P_NUM: begin
				op_a = {praw[32:0], 31'd0} - rb_q;
				op_b = PRESS_SCALE;
			end
			ST_P_PS: begin
				op_a = ps;
				op_b = p9;
			end
			ST_P_PS2: begin
				op_a = ra_q;
				op_b = ps;
			end
			ST_P_P8: begin
				op_a = p8;
				op_b = rd_q;
			end
			ST_P_OUT: begin
				op_a = p7;
				op_b = P7_MULT;
			end
			default: begin
				op_a = ra_q;
				op_b = rb_q;
			end
		endcase
	end

	bsc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_go),
		.a      (op_a),
		.b      (op_b),
		.done   (mul_done),
		.prod   (prod)
	);

	bsc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_go),
		.dividend (ra_q),
		.divisor  (rc_q),
		.done     (div_done),
		.quotient (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_cal_q <= '0;
			press_a_q  <= '0;
			press_b_q  <= '0;
			press_c_q  <= '0;
			fine_q     <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_TEMP:    temp_cal_q <= cfg_data[47:0];
					CFG_PRESS_A: press_a_q  <= cfg_data;
					CFG_PRESS_B: press_b_q  <= cfg_data;
					CFG_PRESS_C: press_c_q  <= cfg_data[15:0];
					default:     press_c_q  <= press_c_q;
				endcase
			end
			if (cmd.wb && cmd.step == ST_T_V2) begin
				fine_q <= ra_q[31:0] + v1_v2_low(prod);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			raw_q   <= in_data.raw_value;
			tcent_q <= '0;
			press_q <= '0;
			dbz_q   <= 1'b0;
		end
		if (cmd.div_take) rd_q <= quot;
		if (cmd.wb) begin
			case (cmd.step)
				ST_T_DIFF: ra_q <= $signed(prod) >>> 11;
				ST_T_SQ:   rb_q <= $signed(prod) >>> 12;
				ST_T_V2:   rb_q <= prod;
				ST_T_OUT:  tcent_q <= asr8_low(prod + ROUND_HALF);
				ST_P_SQ:   ra_q <= prod;
				ST_P_V2A:  rb_q <= prod;
				ST_P_V2B:  rb_q <= rb_q + {prod[46:0], 17'd0};
				ST_P_V1A: begin
					rc_q <= $signed(prod) >>> 8;
					rb_q <= rb_q + {p4[28:0], 35'd0};
				end
				ST_P_V1B:  rc_q <= rc_q + {prod[51:0], 12'd0} + BIAS_47;
				ST_P_V1C: begin
					rc_q  <= v1_new;
					dbz_q <= (v1_new == 64'd0);
				end
				ST_P_NUM:  ra_q <= prod;
				ST_P_PS:   ra_q <= prod;
				ST_P_PS2:  ra_q <= $signed(prod) >>> 25;
				ST_P_P8:   rb_q <= $signed(prod) >>> 19;
				ST_P_OUT:  press_q <= asr8_low(rd_q + ra_q + rb_q) + prod[31:0];
				default:   ra_q <= ra_q;
			endcase
		end
		if (cmd.out_load) begin
			out_q.temperature_centi <= tcent_q;
			out_q.pressure_q8       <= press_q;
			out_q.divide_by_zero    <= dbz_q;
		end
	end

	assign status.mul_done = mul_done;
	assign status.div_done = div_done;
	assign status.div_zero = (rc_q == 64'd0);
	assign out_data        = out_q;

endmodule

// File: hdl/bsc_ctrl.sv
// Controller: sequences the multiply steps, the divide and the output handoff.
module bsc_ctrl import bsc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       opcode,
	input  logic       out_ready,
	input  dp_status_t status,
	output logic       in_ready,
	output logic       out_valid,
	output ctrl_cmd_t  cmd
);

	fsm_t  state_q, state_d;
	step_t step_q, step_d;
	logic  out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CS_IDLE;
			step_q      <= ST_T_DIFF;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		case (state_q)
			CS_IDLE: begin
				if (in_valid) begin
					state_d = CS_MUL_GO;
					step_d  = (opcode == OP_PRESS) ? ST_P_SQ : ST_T_DIFF;
				end
			end
			CS_MUL_GO: state_d = CS_MUL_WAIT;
			CS_MUL_WAIT: if (status.mul_done) state_d = CS_WB;
			CS_WB: begin
				case (step_q)
					ST_T_OUT, ST_P_OUT: state_d = CS_OUT;
					ST_P_NUM: state_d = CS_DIV_GO;
					default: begin
						step_d  = step_t'(step_q + 4'd1);
						state_d = CS_MUL_GO;
					end
				endcase
			end
			CS_DIV_GO: state_d = status.div_zero ? CS_OUT : CS_DIV_WAIT;
			CS_DIV_WAIT: if (status.div_done) state_d = CS_DIV_TAKE;
			CS_DIV_TAKE: begin
				step_d  = ST_P_PS;
				state_d = CS_MUL_GO;
			end
			CS_OUT: if (!out_valid_q || out_ready) state_d = CS_IDLE;
			default: state_d = CS_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.step     = step_q;
		cmd.accept   = (state_q == CS_IDLE) && in_valid;
		cmd.mul_go   = (state_q == CS_MUL_GO);
		cmd.wb       = (state_q == CS_WB);
		cmd.div_go   = (state_q == CS_DIV_GO) && !status.div_zero;
		cmd.div_take = (state_q == CS_DIV_TAKE);
		cmd.out_load = (state_q == CS_OUT) && (!out_valid_q || out_ready);
	end

	assign in_ready  = (state_q == CS_IDLE);
	assign out_valid = out_valid_q;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("output register overwritten while full");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == CS_MUL_GO))
		else $error("accepted item did not start");

	a_mul_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		status.mul_done |-> (state_q == CS_MUL_WAIT))
		else $error("multiplier finished outside wait state");

	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		status.div_done |-> (state_q == CS_DIV_WAIT))
		else $error("divider finished outside wait state");

endmodule

// File: hdl/baro_sensor_compensation_unit.sv
// Top level of the barometric sensor compensation unit.
//
// Usage: send items on in_valid/in_ready/in_data; opcode 0 is a temperature
// reading, 1 a pressure reading. Results leave on out_valid/out_ready/out_data,
// one per item, in order. Calibration words are written on cfg_valid/cfg_ready
// with cfg_index 0..3 and cfg_data; cfg_ready is always high, and writes belong
// in idle periods. One item is worked on at a time through a shared
// 32x32 multiplier, which builds each 64-bit product from partial products,
// and a one-bit-per-cycle divider. A pressure item needs 11 products and a
// divide; when the divisor is zero it skips the divide and the products
// after it. in_ready is high only when idle. The result sits in an output
// register; a stalled receiver holds the next result in the datapath work
// registers, with the controller waiting, until that register frees. Reset
// clears calibration and the stored fine temperature to zero.
module baro_sensor_compensation_unit import bsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	bsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.opcode    (in_data.opcode),
		.out_ready (out_ready),
		.status    (status),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	bsc_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.out_data  (out_data)
	);

endmodule

// File: dv/baro_sensor_compensation_unit_tb.sv
// Self-checking testbench for the barometric compensation unit: directed and random items.
module baro_sensor_compensation_unit_tb;
	import bsc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic        op;
		logic [19:0] raw;
		bit          typed;
		out_item_t   want;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;

	logic [47:0] cal_temp;
	logic [63:0] cal_press_a;
	logic [63:0] cal_press_b;
	logic [15:0] cal_press_c;
	logic [31:0] fine_temp;

	out_item_t pending_results[$];
	int        snd_idle_pct;
	int        rcv_idle_pct;
	int        hold_requests;
	int        mismatches;
	int        results_seen;
	int        items_sent;
	int        zero_div_seen;

	baro_sensor_compensation_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#16ms;
		$display("CHECK FAILED");
		$finish;
	end

	// Compensation formulas; updates the fine temperature on temperature items.
	function automatic out_item_t compensate(logic op, logic [19:0] raw);
		longint t1, t2, t3, a, b, v1, v2, tf;
		longint p1, p2, p3, p4, p5, p6, p7, p8, p9, p, ps, num;
		out_item_t r;
		r = '0;
		if (op == OP_TEMP) begin
			t1 = longint'({48'd0, cal_temp[15:0]});
			t2 = longint'(signed'(cal_temp[31:16]));
			t3 = longint'(signed'(cal_temp[47:32]));
			a = longint'({44'd0, raw >> 3}) - (t1 <<< 1);
			v1 = (a * t2) >>> 11;
			b = longint'({44'd0, raw >> 4}) - t1;
			v2 = (((b * b) >>> 12) * t3) >>> 14;
			tf = v1 + v2;
			fine_temp = tf[31:0];
			tf = longint'(signed'(fine_temp));
			tf = (tf * 5 + 128) >>> 8;
			r.temperature_centi = tf[31:0];
		end else begin
			p1 = longint'({48'd0, cal_press_a[15:0]});
			p2 = longint'(signed'(cal_press_a[31:16]));
			p3 = longint'(signed'(cal_press_a[47:32]));
			p4 = longint'(signed'(cal_press_a[63:48]));
			p5 = longint'(signed'(cal_press_b[15:0]));
			p6 = longint'(signed'(cal_press_b[31:16]));
			p7 = longint'(signed'(cal_press_b[47:32]));
			p8 = longint'(signed'(cal_press_b[63:48]));
			p9 = longint'(signed'(cal_press_c));
			v1 = longint'(signed'(fine_temp)) - 64'sd128000;
			v2 = v1 * v1 * p6;
			v2 = v2 + ((v1 * p5) <<< 17);
			v2 = v2 + (p4 <<< 35);
			v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
			v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
			if (v1 == 0) begin
				r.divide_by_zero = 1'b1;
				return r;
			end
			p = 64'sd1048576 - longint'({44'd0, raw});
			num = ((p <<< 31) - v2) * 64'sd3125;
			p = (v1 == -1) ? -num : num / v1;
			ps = p >>> 13;
			v1 = (p9 * ps * ps) >>> 25;
			v2 = (p8 * p) >>> 19;
			p = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
			r.pressure_q8 = p[31:0];
		end
		return r;
	endfunction

	task automatic send_item(logic op, logic [19:0] raw, bit typed, out_item_t want);
		out_item_t r;
		while ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{opcode: op, raw_value: raw};
		do @(posedge clk); while (!in_ready);
		r = compensate(op, raw);
		pending_results.push_back(typed ? want : r);
		items_sent++;
	endtask

	task automatic write_reg(logic [1:0] idx, logic [63:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_TEMP:    cal_temp    = value[47:0];
			CFG_PRESS_A: cal_press_a = value;
			CFG_PRESS_B: cal_press_b = value;
			CFG_PRESS_C: cal_press_c = value[15:0];
			default: ;
		endcase
	endtask

	task automatic load_calibration(logic [47:0] t, logic [63:0] pa, logic [63:0] pb,
			logic [15:0] pc);
		write_reg(CFG_TEMP, {16'd0, t});
		write_reg(CFG_PRESS_A, pa);
		write_reg(CFG_PRESS_B, pb);
		write_reg(CFG_PRESS_C, {48'd0, pc});
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Receiver: random back-pressure plus long hold-offs on request.
	initial begin
		int seen_holds;
		int hold_left;
		seen_holds = 0;
		hold_left  = 0;
		out_ready  = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests != seen_holds) begin
				seen_holds = hold_requests;
				hold_left  = 800;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= rcv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (out_data.divide_by_zero) zero_div_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", out_data);
			end else begin
				want = pending_results.pop_front();
				if (out_data.temperature_centi !== want.temperature_centi
						|| out_data.pressure_q8 !== want.pressure_q8
						|| out_data.divide_by_zero !== want.divide_by_zero) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", want, out_data);
				end
			end
		end
	end

	localparam logic [47:0] REAL_T = {16'hFC18, 16'd26435, 16'd27504};
	localparam logic [63:0] REAL_PA = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
	localparam logic [63:0] REAL_PB = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
	localparam logic [15:0] REAL_PC = 16'd6000;

	initial begin
		stim_row_t zero_rows[4];
		stim_row_t cal_rows[7];
		out_item_t no_out;
		out_item_t zdiv;
		int phase;
		int k;
		no_out = '0;
		zdiv = '0;
		zdiv.divide_by_zero = 1'b1;
		// zero calibration: temperature reads 0, pressure divisor is zero
		zero_rows[0] = '{OP_TEMP,  20'h00000, 1'b1, no_out};
		zero_rows[1] = '{OP_PRESS, 20'h00000, 1'b1, zdiv};
		zero_rows[2] = '{OP_PRESS, 20'hFFFFF, 1'b1, zdiv};
		zero_rows[3] = '{OP_TEMP,  20'hFFFFF, 1'b1, no_out};
		// pressure first, so the zero fine temperature left by the earlier run is used
		cal_rows[0] = '{OP_PRESS, 20'd415148, 1'b0, no_out};
		cal_rows[1] = '{OP_TEMP,  20'h00000,  1'b0, no_out};
		cal_rows[2] = '{OP_PRESS, 20'h00000,  1'b0, no_out};
		cal_rows[3] = '{OP_TEMP,  20'hFFFFF,  1'b0, no_out};
		cal_rows[4] = '{OP_PRESS, 20'hFFFFF,  1'b0, no_out};
		cal_rows[5] = '{OP_TEMP,  20'd519888, 1'b0, no_out};
		cal_rows[6] = '{OP_PRESS, 20'd415148, 1'b0, no_out};

		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_TEMP;
		cfg_data = '0;
		cal_temp = '0;
		cal_press_a = '0;
		cal_press_b = '0;
		cal_press_c = '0;
		fine_temp = '0;
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		hold_requests = 0;
		mismatches = 0;
		results_seen = 0;
		items_sent = 0;
		zero_div_seen = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (zero_rows[i])
			send_item(zero_rows[i].op, zero_rows[i].raw, 1'b1, zero_rows[i].want);
		drain();
		for (int c = 0; c < 2; c++) begin
			case (c)
				0: load_calibration(REAL_T, REAL_PA, REAL_PB, REAL_PC);
				default: load_calibration('1, '1, '1, '1);
			endcase
			for (int i = (c == 0) ? 0 : 1; i < 7; i++)
				send_item(cal_rows[i].op, cal_rows[i].raw, 1'b0, no_out);
			drain();
		end

		for (phase = 0; phase < 7; phase++) begin
			snd_idle_pct = (phase < 2) ? 19 : (phase < 4) ? 75 : 0;
			rcv_idle_pct = (phase < 2) ? 75 : (phase < 4) ? 19 : 0;
			case (phase)
				0: load_calibration(REAL_T, REAL_PA, REAL_PB, REAL_PC);
				1: load_calibration({16'h8000, 16'h8000, 16'h0000},
						{16'h8000, 16'h8000, 16'h8000, 16'hFFFF},
						{4{16'h8000}}, 16'h8000);
				2: load_calibration(48'd0, {rand64() & 64'hFFFF_FFFF_FFFF_0000},
						rand64(), 16'($urandom()));
				default: load_calibration(48'(rand64()), rand64(), rand64(),
						16'($urandom()));
			endcase
			for (k = 0; k < 100; k++) begin
				if (phase == 3 && k == 30) hold_requests++;
				if (phase == 5 && k == 50) begin
					in_valid <= 1'b0;
					while (pending_results.size() != 0) @(posedge clk);
				end
				if (phase == 0)
					send_item(1'($urandom_range(1)),
						20'd400000 + 20'($urandom_range(200000)), 1'b0, no_out);
				else
					send_item(1'($urandom_range(1)), 20'($urandom()), 1'b0, no_out);
			end
			drain();
		end

		$display("%0d items sent, %0d results checked (%0d zero-divisor), 9 calibration sets",
			items_sent, results_seen, zero_div_seen);
		$display("back-pressure, sender gaps, long receiver hold-off and pause covered");
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
